@@ sv/nrp_pkg.sv @@
// Package for the nested region profiler.
// Holds the sequencer state type, command and result-kind codes and fixed field widths.
// No dependencies.
package nrp_pkg;

    localparam int TYPE_W   = 6;
    localparam int COUNT_W  = 32;
    localparam int PERIOD_W = 16;
    localparam int SUM_W    = 17;
    localparam int PERIOD_RESET = 10000;

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_END   = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_REPORT   = 2'd0,
        KIND_OVERFLOW = 2'd1,
        KIND_MISMATCH = 2'd2
    } kind_t;

    typedef enum logic {
        REG_ENABLE = 1'b0,
        REG_PERIOD = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_END_CHK,
        ST_END_UPD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SCAN_NEXT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

endpackage

@@ sv/nrp_divider.sv @@
// Restoring divider for the report average, one quotient bit per cycle.
// Depends on nothing; used by nested_region_profiler.
module nrp_divider #(
    parameter int DW = 48,
    parameter int VW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] q_reg;
    logic [VW-1:0] r_reg;
    logic [VW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic [VW:0]   rem_shift;
    logic          ge;

    assign rem_shift = {r_reg, q_reg[DW-1]};
    assign ge        = rem_shift >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CW'(DW);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (cnt_reg != '0) begin
            q_reg <= {q_reg[DW-2:0], ge};
            r_reg <= ge ? VW'(rem_shift - {1'b0, d_reg}) : rem_shift[VW-1:0];
        end
    end

    assign busy     = cnt_reg != '0;
    assign quotient = q_reg;

endmodule

@@ sv/nested_region_profiler.sv @@
// Nested region profiler: region stack, per-type count and time table, periodic report.
// Begin and a tick without report finish in the idle state (an overflow adds a record);
// end reads the stack top, then updates the table; a report scans every type and runs the
// serial divider per listed type. One transaction at a time. Reset is synchronous, active
// low; afterwards a clearing pass zeroes all NUM_TYPES table entries, accepting no input.
module nested_region_profiler
    import nrp_pkg::*;
#(
    parameter int STACK_DEPTH = 32,
    parameter int NUM_TYPES   = 64,
    parameter int TIME_WIDTH  = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [PERIOD_W-1:0]   cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_command,
    input  logic [TYPE_W-1:0]     s_region_type,
    input  logic [TIME_WIDTH-1:0] s_timestamp_us,
    input  logic [PERIOD_W-1:0]   s_tick_interval,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_kind,
    output logic [TYPE_W-1:0]     m_report_type,
    output logic [COUNT_W-1:0]    m_call_count,
    output logic [TIME_WIDTH-1:0] m_total_time,
    output logic [TIME_WIDTH-1:0] m_average_time,
    output logic                  m_last
);

    localparam int SA = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int TA = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

    state_t state_reg, state_next;

    logic                  enable_reg, halted_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [DW-1:0]         depth_reg;
    logic [TA-1:0]         idx_reg;

    logic [TYPE_W-1:0]     type_reg;
    logic [TIME_WIDTH-1:0] ts_reg;
    logic [TIME_WIDTH-1:0] elapsed_reg;

    // stack memory
    logic [TYPE_W-1:0]     stk_type_mem  [STACK_DEPTH];
    logic [TIME_WIDTH-1:0] stk_start_mem [STACK_DEPTH];
    logic [TYPE_W-1:0]     stk_type_reg;
    logic [TIME_WIDTH-1:0] stk_start_reg;
    logic                  stk_we;
    logic [SA-1:0]         stk_wa, stk_ra;

    // type table memory
    logic [COUNT_W-1:0]    cnt_mem [NUM_TYPES];
    logic [TIME_WIDTH-1:0] tot_mem [NUM_TYPES];
    logic [COUNT_W-1:0]    cnt_rd_reg;
    logic [TIME_WIDTH-1:0] tot_rd_reg;
    logic                  tbl_we;
    logic [TA-1:0]         tbl_wa, tbl_ra;
    logic [COUNT_W-1:0]    tbl_wcnt;
    logic [TIME_WIDTH-1:0] tbl_wtot;

    // pending report entry and staged result
    logic                  pend_v_reg;
    logic [TYPE_W-1:0]     pend_type_reg;
    logic [COUNT_W-1:0]    pend_cnt_reg;
    logic [TIME_WIDTH-1:0] pend_tot_reg;
    logic [1:0]            o_kind_reg;
    logic [TYPE_W-1:0]     o_type_reg;
    logic [COUNT_W-1:0]    o_cnt_reg;
    logic [TIME_WIDTH-1:0] o_tot_reg;
    logic                  o_last_reg;

    logic                  m_valid_reg;

    logic                  accept, run, in_tbl, nz, idx_final, div_busy, div_start;
    logic [TA-1:0]         type_addr;
    logic [SUM_W-1:0]      sum_add;
    logic [TIME_WIDTH:0]   tot_sum;
    logic [TIME_WIDTH-1:0] quotient;

    assign accept    = s_valid && s_ready;
    assign run       = enable_reg && !halted_reg;
    assign in_tbl    = 32'(type_reg) < NUM_TYPES;
    assign type_addr = TA'(type_reg);
    assign nz        = cnt_rd_reg != '0;
    assign idx_final = 32'(idx_reg) == NUM_TYPES - 1;
    assign sum_add   = sum_reg + SUM_W'(s_tick_interval);
    assign tot_sum   = {1'b0, tot_rd_reg} + {1'b0, elapsed_reg};
    assign div_start = state_reg == ST_DIV_GO;

    assign stk_we = accept && run && cmd_t'(s_command) == CMD_BEGIN
                    && 32'(depth_reg) < STACK_DEPTH;
    assign stk_wa = SA'(depth_reg);
    assign stk_ra = SA'(depth_reg - 1'b1);

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_type_mem[stk_wa]  <= s_region_type;
            stk_start_mem[stk_wa] <= s_timestamp_us;
        end
        stk_type_reg  <= stk_type_mem[stk_ra];
        stk_start_reg <= stk_start_mem[stk_ra];
    end

    always_comb begin
        tbl_we   = 1'b0;
        tbl_wa   = idx_reg;
        tbl_wcnt = '0;
        tbl_wtot = '0;
        if (state_reg == ST_CLEAR) begin
            tbl_we = 1'b1;
        end else if (state_reg == ST_END_UPD) begin
            tbl_we   = 1'b1;
            tbl_wa   = type_addr;
            tbl_wcnt = (cnt_rd_reg == '1) ? cnt_rd_reg : cnt_rd_reg + 1'b1;
            tbl_wtot = tot_sum[TIME_WIDTH] ? '1 : tot_sum[TIME_WIDTH-1:0];
        end
    end

    assign tbl_ra = (state_reg == ST_SCAN_RD) ? idx_reg : type_addr;

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            cnt_mem[tbl_wa] <= tbl_wcnt;
            tot_mem[tbl_wa] <= tbl_wtot;
        end
        cnt_rd_reg <= cnt_mem[tbl_ra];
        tot_rd_reg <= tot_mem[tbl_ra];
    end

    nrp_divider #(
        .DW (TIME_WIDTH),
        .VW (COUNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (o_tot_reg),
        .divisor  (o_cnt_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (idx_final) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept && run) begin
                    unique case (cmd_t'(s_command))
                        CMD_BEGIN: begin
                            if (32'(depth_reg) >= STACK_DEPTH) state_next = ST_EMIT;
                        end
                        CMD_END: begin
                            state_next = (depth_reg == '0) ? ST_EMIT : ST_END_CHK;
                        end
                        CMD_TICK: begin
                            if (sum_add >= SUM_W'(period_reg)) state_next = ST_SCAN_RD;
                        end
                        CMD_NONE: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_END_CHK: begin
                if (stk_type_reg != type_reg) state_next = ST_EMIT;
                else if (in_tbl)              state_next = ST_END_UPD;
                else                          state_next = ST_IDLE;
            end
            ST_END_UPD:  state_next = ST_IDLE;
            ST_SCAN_RD:  state_next = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                state_next = (nz && pend_v_reg) ? ST_DIV_GO : ST_SCAN_NEXT;
            end
            ST_SCAN_NEXT: begin
                if (!idx_final)      state_next = ST_SCAN_RD;
                else if (pend_v_reg) state_next = ST_DIV_GO;
                else                 state_next = ST_IDLE;
            end
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (!div_busy) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg) begin
                    state_next = (o_kind_reg == KIND_REPORT) ? ST_SCAN_NEXT : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b0;
            halted_reg  <= 1'b0;
            period_reg  <= PERIOD_W'(PERIOD_RESET);
            sum_reg     <= '0;
            depth_reg   <= '0;
            idx_reg     <= '0;
            pend_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (reg_idx_t'(cfg_addr))
                    REG_ENABLE: begin
                        enable_reg <= cfg_wdata[0];
                        if (cfg_wdata[0]) halted_reg <= 1'b0;
                    end
                    REG_PERIOD: period_reg <= cfg_wdata;
                endcase
            end
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR: idx_reg <= idx_reg + 1'b1;
                ST_IDLE: begin
                    if (accept && run) begin
                        if (stk_we) depth_reg <= depth_reg + 1'b1;
                        if (cmd_t'(s_command) == CMD_BEGIN && !stk_we) halted_reg <= 1'b1;
                        if (cmd_t'(s_command) == CMD_END && depth_reg == '0) begin
                            halted_reg <= 1'b1;
                        end
                        if (cmd_t'(s_command) == CMD_TICK) begin
                            if (sum_add >= SUM_W'(period_reg)) begin
                                sum_reg    <= '0;
                                idx_reg    <= '0;
                                pend_v_reg <= 1'b0;
                            end else begin
                                sum_reg <= sum_add;
                            end
                        end
                    end
                end
                ST_END_CHK: begin
                    if (stk_type_reg != type_reg) halted_reg <= 1'b1;
                    else if (!in_tbl)             depth_reg  <= depth_reg - 1'b1;
                end
                ST_END_UPD: depth_reg <= depth_reg - 1'b1;
                ST_SCAN_CHK: begin
                    if (nz) pend_v_reg <= 1'b1;
                end
                ST_SCAN_NEXT: begin
                    if (!idx_final) idx_reg <= idx_reg + 1'b1;
                    else if (pend_v_reg) pend_v_reg <= 1'b0;
                end
                ST_EMIT: begin
                    if (!m_valid_reg) m_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    type_reg   <= s_region_type;
                    ts_reg     <= s_timestamp_us;
                    o_type_reg <= s_region_type;
                    o_cnt_reg  <= '0;
                    o_tot_reg  <= '0;
                    o_last_reg <= 1'b1;
                    o_kind_reg <= (cmd_t'(s_command) == CMD_BEGIN) ? KIND_OVERFLOW
                                                                   : KIND_MISMATCH;
                end
            end
            ST_END_CHK: elapsed_reg <= ts_reg - stk_start_reg;
            ST_SCAN_CHK: begin
                if (nz) begin
                    // hand the older entry to the divider, hold the new one back
                    o_kind_reg    <= KIND_REPORT;
                    o_type_reg    <= pend_type_reg;
                    o_cnt_reg     <= pend_cnt_reg;
                    o_tot_reg     <= pend_tot_reg;
                    o_last_reg    <= 1'b0;
                    pend_type_reg <= TYPE_W'(idx_reg);
                    pend_cnt_reg  <= cnt_rd_reg;
                    pend_tot_reg  <= tot_rd_reg;
                end
            end
            ST_SCAN_NEXT: begin
                if (idx_final) begin
                    o_kind_reg <= KIND_REPORT;
                    o_type_reg <= pend_type_reg;
                    o_cnt_reg  <= pend_cnt_reg;
                    o_tot_reg  <= pend_tot_reg;
                    o_last_reg <= 1'b1;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg) begin
                    m_kind         <= o_kind_reg;
                    m_report_type  <= o_type_reg;
                    m_call_count   <= o_cnt_reg;
                    m_total_time   <= o_tot_reg;
                    m_average_time <= (o_kind_reg == KIND_REPORT) ? quotient : '0;
                    m_last         <= o_last_reg;
                end
            end
            default: ;
        endcase
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

endmodule
